@@ design/rtt_pkg.sv @@
// ----------------------------------------------------------------------------
// Relay transaction table package
// Shared widths, payload and entry types, register indexes and the control
// state encoding of the relay transaction table.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int ID_W   = 32;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int HW_W   = 48;

    localparam int BUCKETS_DEF = 64;
    localparam int WAYS_DEF    = 4;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SERVER_IP   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SERVER_PORT = CFG_INDEX_W'(1);

    localparam logic [IP_W-1:0]   SERVER_IP_RST   = '0;
    localparam logic [PORT_W-1:0] SERVER_PORT_RST = PORT_W'(67);

    typedef struct packed {
        logic [ID_W-1:0]   trans_id;
        logic [IP_W-1:0]   src_ip;
        logic [PORT_W-1:0] src_port;
        logic [HW_W-1:0]   hw_addr;
    } in_t;

    typedef struct packed {
        logic              to_client;
        logic [IP_W-1:0]   dest_ip;
        logic [PORT_W-1:0] dest_port;
        logic [HW_W-1:0]   stored_hw_addr;
        logic              not_recorded;
    } out_t;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [HW_W-1:0]   hw;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

endpackage

@@ design/rtt_mod.sv @@
// ----------------------------------------------------------------------------
// Bucket index unit
// Reduces a transaction id modulo the bucket count. A power-of-two count
// registers the low bits; any other count multiplies by a fixed
// reciprocal for the quotient, then subtracts quotient times count, each
// step registered.
// ----------------------------------------------------------------------------
module rtt_mod #(
    parameter int BUCKETS = rtt_pkg::BUCKETS_DEF,
    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [rtt_pkg::ID_W-1:0] trans_id,
    output logic [BUCKET_W-1:0]     bucket,
    output logic                    done
);
    import rtt_pkg::*;

    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            logic [BUCKET_W-1:0] bucket_reg;
            logic                done_reg;

            always_ff @(posedge aclk) begin
                if (start) begin
                    bucket_reg <= BUCKET_W'(trans_id) & BUCKET_W'(BUCKETS - 1);
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else if (start) begin
                    done_reg <= 1'b1;
                end
            end

            assign bucket = bucket_reg;
            assign done   = done_reg;
        end else begin : g_recip
            localparam int RECIP_W = ID_W + 1;
            localparam int PROD_W  = ID_W + RECIP_W;
            localparam int SHIFT   = ID_W + BUCKET_W;
            localparam logic [63:0] RECIP_FULL =
                ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
            localparam logic [RECIP_W-1:0]  RECIP   = RECIP_W'(RECIP_FULL);
            localparam logic [BUCKET_W-1:0] DIVISOR = BUCKET_W'(BUCKETS);

            logic [PROD_W-1:0]   prod;
            logic [ID_W-1:0]     id_reg;
            logic [BUCKET_W-1:0] quot_reg;
            logic [BUCKET_W-1:0] rem_reg;
            logic                mul_reg;
            logic                sub_reg;
            logic                done_reg;

            assign prod = PROD_W'(id_reg) * PROD_W'(RECIP);

            always_ff @(posedge aclk) begin
                if (start) begin
                    id_reg <= trans_id;
                end
                if (mul_reg) begin
                    quot_reg <= BUCKET_W'(prod >> SHIFT);
                end
                if (sub_reg) begin
                    rem_reg <= id_reg[BUCKET_W-1:0] - quot_reg * DIVISOR;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    mul_reg  <= 1'b0;
                    sub_reg  <= 1'b0;
                    done_reg <= 1'b0;
                end else begin
                    mul_reg <= start;
                    sub_reg <= mul_reg;
                    if (start) begin
                        done_reg <= 1'b0;
                    end else if (sub_reg) begin
                        done_reg <= 1'b1;
                    end
                end
            end

            assign bucket = rem_reg;
            assign done   = done_reg;
        end
    endgenerate

endmodule

@@ design/rtt_table.sv @@
// ----------------------------------------------------------------------------
// Bucket memory
// One row per bucket holding all of its ways. One write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module rtt_table #(
    parameter int BUCKETS = rtt_pkg::BUCKETS_DEF,
    parameter int WAYS    = rtt_pkg::WAYS_DEF,
    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [BUCKET_W-1:0]          wr_addr,
    input  rtt_pkg::entry_t [WAYS-1:0]   wr_row,
    input  logic                         rd_en,
    input  logic [BUCKET_W-1:0]          rd_addr,
    output rtt_pkg::entry_t [WAYS-1:0]   rd_row
);
    import rtt_pkg::*;

    entry_t [WAYS-1:0] mem [BUCKETS];
    entry_t [WAYS-1:0] rd_row_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

@@ design/relay_transaction_table.sv @@
// ----------------------------------------------------------------------------
// Relay transaction table
// Looks up relay packet headers by transaction id in a bucketed table and
// returns where each packet is to be forwarded.
// ----------------------------------------------------------------------------
// After reset the block clears the bucket memory, one row per cycle, and takes
// no beat until that is done. Each header beat then goes through the bucket
// index, a read of the bucket row and an update of that row that also loads
// the result. A power-of-two bucket index is ready at the accepting edge,
// while any other count first registers a reciprocal multiply and then a
// remainder subtract. The next beat is taken in the update cycle, so items
// overlap. A held result stalls only the update, and with it the taking of
// the next beat; configuration writes are accepted in every cycle out of
// reset and must be made while the block is idle.
module relay_transaction_table #(
    parameter int BUCKETS = rtt_pkg::BUCKETS_DEF,
    parameter int WAYS    = rtt_pkg::WAYS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rtt_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rtt_pkg::out_t                     m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rtt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rtt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import rtt_pkg::*;

    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

    state_t              state_reg, state_next;
    in_t                 in_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [BUCKET_W-1:0] clr_idx_reg;
    logic [IP_W-1:0]     server_ip_reg;
    logic [PORT_W-1:0]   server_port_reg;
    out_t                out_reg, out_next;
    logic                m_valid_reg;

    logic                s_accept;
    logic                out_free;
    logic                load_out;
    logic                clr_last;
    logic                mod_done;
    logic [BUCKET_W-1:0] mod_bucket;
    logic                tbl_wr_en;
    logic [BUCKET_W-1:0] tbl_wr_addr;
    entry_t [WAYS-1:0]   tbl_wr_row;
    logic                tbl_rd_en;
    entry_t [WAYS-1:0]   rd_row;
    entry_t [WAYS-1:0]   upd_row;
    logic [WAYS-1:0]     hit_vec;
    logic [WAYS-1:0]     free_vec;
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    free_idx;

    rtt_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_accept),
        .trans_id (s_data.trans_id),
        .bucket   (mod_bucket),
        .done     (mod_done)
    );

    rtt_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_row  (tbl_wr_row),
        .rd_en   (tbl_rd_en),
        .rd_addr (mod_bucket),
        .rd_row  (rd_row)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign clr_last = clr_idx_reg == BUCKET_W'(BUCKETS - 1);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (mod_done) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) state_next = s_valid ? ST_LOOKUP : ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = bucket_reg;
        tbl_wr_row  = upd_row;
        tbl_rd_en   = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = clr_idx_reg;
                tbl_wr_row  = '0;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_LOOKUP: begin
                tbl_rd_en = mod_done;
            end
            ST_UPDATE: begin
                s_ready   = out_free;
                tbl_wr_en = out_free;
                load_out  = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]  = rd_row[w].valid && (rd_row[w].id == in_reg.trans_id);
            free_vec[w] = !rd_row[w].valid;
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) hit_idx = WAY_W'(w);
            if (free_vec[w]) free_idx = WAY_W'(w);
        end
    end

    always_comb begin
        upd_row  = rd_row;
        out_next = '0;
        if (|hit_vec) begin
            out_next.to_client      = 1'b1;
            out_next.dest_ip        = rd_row[hit_idx].ip;
            out_next.dest_port      = rd_row[hit_idx].port;
            out_next.stored_hw_addr = rd_row[hit_idx].hw;
            upd_row[hit_idx].valid  = 1'b0;
        end else begin
            out_next.dest_ip   = server_ip_reg;
            out_next.dest_port = server_port_reg;
            if (|free_vec) begin
                upd_row[free_idx].valid = 1'b1;
                upd_row[free_idx].id    = in_reg.trans_id;
                upd_row[free_idx].ip    = in_reg.src_ip;
                upd_row[free_idx].port  = in_reg.src_port;
                upd_row[free_idx].hw    = in_reg.hw_addr;
            end else begin
                out_next.not_recorded = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_idx_reg     <= '0;
            m_valid_reg     <= 1'b0;
            server_ip_reg   <= SERVER_IP_RST;
            server_port_reg <= SERVER_PORT_RST;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + BUCKET_W'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SERVER_IP:   server_ip_reg   <= cfg_wdata[IP_W-1:0];
                    REG_SERVER_PORT: server_port_reg <= cfg_wdata[PORT_W-1:0];
                    default:         server_ip_reg   <= server_ip_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_reg <= s_data;
        end
        if (tbl_rd_en) begin
            bucket_reg <= mod_bucket;
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign cfg_ready = aresetn;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("Header beat offered a slot during the clearing pass.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_LOOKUP))
        else $error("Accepted header beat did not start a lookup.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && !out_free) |=> (state_reg == ST_UPDATE))
        else $error("Bucket update left while the result register was held.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.to_client) |-> !m_data.not_recorded)
        else $error("Hit result was flagged as not recorded.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.to_client) |-> (m_data.stored_hw_addr == '0))
        else $error("Miss result carried a stored hardware address.");

endmodule
